// ===== hdl/ertm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ertm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // fixed field widths of the ports
    localparam int ANGLE_W = 16;
    localparam int FIELD_W = 16;

    // internal fraction width of the sine/cosine datapath
    localparam int Q = 30;

    localparam int HORNER_STEPS = 8;
    localparam int STEP_LAT     = 3;
    localparam int HORNER_LAT   = HORNER_STEPS * STEP_LAT;
    localparam int LANE_LAT     = 2 + HORNER_LAT + 2;
    localparam int MERGE_LAT    = 4;
    localparam int TOTAL_LAT    = LANE_LAT + MERGE_LAT;

    localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [31:0] QONE        = 32'sd1073741824;
    localparam logic [63:0]        QHALF       = 64'd536870912;

    localparam int unsigned COS_DIV [HORNER_STEPS] = '{240, 182, 132, 90, 56, 30, 12, 2};
    localparam int unsigned SIN_DIV [HORNER_STEPS] = '{272, 210, 156, 110, 72, 42, 20, 6};

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_sincos;

    typedef struct packed {
        logic signed [FIELD_W-1:0] m00;
        logic signed [FIELD_W-1:0] m01;
        logic signed [FIELD_W-1:0] m02;
        logic signed [FIELD_W-1:0] m10;
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m20;
        logic signed [FIELD_W-1:0] m21;
        logic signed [FIELD_W-1:0] m22;
    } t_matrix;

    // product of two unsigned Q30 magnitudes, rounded half up
    function automatic logic [33:0] mulq_u(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = a * b;
        return 34'((prod + QHALF) >> Q);
    endfunction

    // signed Q30 product: magnitudes multiplied, sign reapplied
    function automatic logic signed [31:0] mulq_s(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [33:0] m;
        ua = a[31] ? (~a + 32'd1) : a;
        ub = b[31] ? (~b + 32'd1) : b;
        m  = mulq_u(ua, ub);
        return (a[31] ^ b[31]) ? -$signed(m[31:0]) : $signed(m[31:0]);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ertm_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One Horner step: t_out = 1 - round_div(x2 * t_in, DIV)
module ertm_div_step #(
    parameter int unsigned DIV = 2
) (
    input  wire                i_clk,
    input  wire         [31:0] i_x2,
    input  wire  signed [31:0] i_t,
    output logic signed [31:0] o_t
);
    import ertm_pkg::*;

    localparam int          RSH    = 33;
    localparam logic [32:0] RECIP  = 33'((64'd1 << RSH) / DIV);
    localparam logic [32:0] HALF_D = 33'(DIV / 2);
    localparam logic [32:0] DIV_W  = 33'(DIV);

    logic [33:0] p_a;
    logic [32:0] r_v_a;

    logic [65:0] prod_b;
    logic [31:0] r_q_b;
    logic [32:0] r_v_b;

    logic [32:0] rem_c;
    logic [32:0] q_c;
    logic [32:0] t_c;
    logic signed [31:0] r_t;

    // stage A: product, add half divisor
    assign p_a = mulq_u(i_x2, {1'b0, i_t[30:0]});

    // stage B: reciprocal estimate, low by at most one
    assign prod_b = r_v_a * RECIP;

    // stage C: correct the quotient and subtract from one
    assign rem_c = r_v_b - {1'b0, r_q_b} * DIV_W;
    assign q_c   = (rem_c >= DIV_W) ? ({1'b0, r_q_b} + 33'd1) : {1'b0, r_q_b};
    assign t_c   = {1'b0, QONE} - q_c;

    always_ff @(posedge i_clk) begin
        r_v_a <= p_a[32:0] + HALF_D;
        r_q_b <= prod_b[64:33];
        r_v_b <= r_v_a;
        r_t   <= t_c[31:0];
    end

    assign o_t = r_t;

endmodule

`default_nettype wire

// ===== hdl/ertm_sincos_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ertm_sincos_lane #(
    parameter int ANGLE_BITS = ertm_pkg::ANGLE_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire [ertm_pkg::ANGLE_W-1:0]  i_angle,
    output ertm_pkg::t_sincos            o_sc
);
    import ertm_pkg::*;

    localparam logic [31:0] AMASK   = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int          PSH     = 32 - ANGLE_BITS;
    localparam int          X2_LINE = (HORNER_STEPS - 1) * STEP_LAT;

    logic [31:0] phase;
    logic [61:0] xr;
    logic [30:0] r_x;
    t_quad       r_quad1;

    logic [33:0] x2_w;
    logic [31:0] r_x2;
    logic [30:0] r_x_2;
    t_quad       r_quad2;

    logic [31:0] r_x2_line [X2_LINE];
    logic [30:0] r_x_line  [HORNER_LAT];
    t_quad       r_quad_line [HORNER_LAT + 1];

    logic [31:0]        x2_tap [HORNER_STEPS];
    logic signed [31:0] cos_t  [HORNER_STEPS + 1];
    logic signed [31:0] sin_t  [HORNER_STEPS + 1];

    logic [33:0]        s_w;
    logic signed [31:0] r_s;
    logic signed [31:0] r_c;
    t_sincos            r_sc;

    assign phase = 32'(({{(32 - ANGLE_W){1'b0}}, i_angle} & AMASK) << PSH);
    assign xr    = phase[29:0] * HALF_PI_Q30 + {32'd0, QHALF[29:0]};
    assign x2_w  = mulq_u({1'b0, r_x}, {1'b0, r_x});

    always_ff @(posedge i_clk) begin
        r_x     <= xr[60:30];
        r_quad1 <= t_quad'(phase[31:30]);
        r_x2    <= x2_w[31:0];
        r_x_2   <= r_x;
        r_quad2 <= r_quad1;

        r_x2_line[0]   <= r_x2;
        r_x_line[0]    <= r_x_2;
        r_quad_line[0] <= r_quad2;
        for (int k = 1; k < X2_LINE; k++) begin
            r_x2_line[k] <= r_x2_line[k-1];
        end
        for (int k = 1; k < HORNER_LAT; k++) begin
            r_x_line[k] <= r_x_line[k-1];
        end
        for (int k = 1; k <= HORNER_LAT; k++) begin
            r_quad_line[k] <= r_quad_line[k-1];
        end
    end

    assign cos_t[0] = QONE;
    assign sin_t[0] = QONE;

    genvar gi;
    generate
        for (gi = 0; gi < HORNER_STEPS; gi++) begin : g_step
            if (gi == 0) begin : g_tap0
                assign x2_tap[gi] = r_x2;
            end else begin : g_tapn
                assign x2_tap[gi] = r_x2_line[gi * STEP_LAT - 1];
            end

            ertm_div_step #(
                .DIV (COS_DIV[gi])
            ) u_cos (
                .i_clk (i_clk),
                .i_x2  (x2_tap[gi]),
                .i_t   (cos_t[gi]),
                .o_t   (cos_t[gi + 1])
            );

            ertm_div_step #(
                .DIV (SIN_DIV[gi])
            ) u_sin (
                .i_clk (i_clk),
                .i_x2  (x2_tap[gi]),
                .i_t   (sin_t[gi]),
                .o_t   (sin_t[gi + 1])
            );
        end
    endgenerate

    assign s_w = mulq_u({1'b0, r_x_line[HORNER_LAT - 1]}, {1'b0, sin_t[HORNER_STEPS][30:0]});

    always_ff @(posedge i_clk) begin
        r_s <= s_w[31:0];
        r_c <= cos_t[HORNER_STEPS];
    end

    // fold the first-quadrant pair out to the full circle
    always_ff @(posedge i_clk) begin
        case (r_quad_line[HORNER_LAT])
            QUAD_0: begin
                r_sc.s <= r_s;
                r_sc.c <= r_c;
            end
            QUAD_1: begin
                r_sc.s <= r_c;
                r_sc.c <= -r_s;
            end
            QUAD_2: begin
                r_sc.s <= -r_s;
                r_sc.c <= -r_c;
            end
            QUAD_3: begin
                r_sc.s <= -r_c;
                r_sc.c <= r_s;
            end
            default: begin
                r_sc.s <= r_s;
                r_sc.c <= r_c;
            end
        endcase
    end

    assign o_sc = r_sc;

endmodule

`default_nettype wire

// ===== hdl/ertm_matrix_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ertm_matrix_merge #(
    parameter int FRAC_BITS = ertm_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  ertm_pkg::t_sincos    i_pitch,
    input  ertm_pkg::t_sincos    i_yaw,
    input  ertm_pkg::t_sincos    i_roll,
    output ertm_pkg::t_matrix    o_mat
);
    import ertm_pkg::*;

    localparam int          SH  = Q - FRAC_BITS;
    localparam logic [32:0] RND = 33'((64'd1 << SH) >> 1);
    localparam logic [32:0] LIM = 33'(64'd1 << FRAC_BITS);

    function automatic logic signed [32:0] ext(input logic signed [31:0] a);
        return {a[31], a};
    endfunction

    // round magnitude half up, saturate to one, reapply sign
    function automatic logic [FIELD_W-1:0] to_field(input logic signed [32:0] v);
        logic [32:0] mag;
        logic [32:0] rnd;
        mag = v[32] ? (~v + 33'd1) : v;
        rnd = (mag + RND) >> SH;
        if (rnd > LIM) begin
            rnd = LIM;
        end
        return v[32] ? FIELD_W'(~rnd + 33'd1) : FIELD_W'(rnd);
    endfunction

    // stage 1
    logic signed [31:0] r_crcy, r_crsy, r_srcy, r_srsy;
    logic signed [31:0] r_m00_1, r_m10_1, r_m21_1, r_m22_1, r_sp_1;
    // stage 2
    logic signed [31:0] r_a01, r_a02, r_a11, r_a12;
    logic signed [31:0] r_crcy_2, r_crsy_2, r_srcy_2, r_srsy_2;
    logic signed [31:0] r_m00_2, r_m10_2, r_m21_2, r_m22_2, r_sp_2;
    // stage 3
    logic signed [32:0] r_sum [9];
    // stage 4
    t_matrix            r_mat;

    always_ff @(posedge i_clk) begin
        r_crcy  <= mulq_s(i_roll.c, i_yaw.c);
        r_crsy  <= mulq_s(i_roll.c, i_yaw.s);
        r_srcy  <= mulq_s(i_roll.s, i_yaw.c);
        r_srsy  <= mulq_s(i_roll.s, i_yaw.s);
        r_m00_1 <= mulq_s(i_pitch.c, i_yaw.c);
        r_m10_1 <= mulq_s(i_pitch.c, i_yaw.s);
        r_m21_1 <= mulq_s(i_roll.s, i_pitch.c);
        r_m22_1 <= mulq_s(i_roll.c, i_pitch.c);
        r_sp_1  <= i_pitch.s;

        r_a01    <= mulq_s(r_sp_1, r_srcy);
        r_a02    <= mulq_s(r_sp_1, r_crcy);
        r_a11    <= mulq_s(r_sp_1, r_srsy);
        r_a12    <= mulq_s(r_sp_1, r_crsy);
        r_crcy_2 <= r_crcy;
        r_crsy_2 <= r_crsy;
        r_srcy_2 <= r_srcy;
        r_srsy_2 <= r_srsy;
        r_m00_2  <= r_m00_1;
        r_m10_2  <= r_m10_1;
        r_m21_2  <= r_m21_1;
        r_m22_2  <= r_m22_1;
        r_sp_2   <= r_sp_1;

        r_sum[0] <= ext(r_m00_2);
        r_sum[1] <= ext(r_a01) - ext(r_crsy_2);
        r_sum[2] <= ext(r_a02) + ext(r_srsy_2);
        r_sum[3] <= ext(r_m10_2);
        r_sum[4] <= ext(r_a11) + ext(r_crcy_2);
        r_sum[5] <= ext(r_a12) - ext(r_srcy_2);
        r_sum[6] <= -ext(r_sp_2);
        r_sum[7] <= ext(r_m21_2);
        r_sum[8] <= ext(r_m22_2);

        r_mat.m00 <= to_field(r_sum[0]);
        r_mat.m01 <= to_field(r_sum[1]);
        r_mat.m02 <= to_field(r_sum[2]);
        r_mat.m10 <= to_field(r_sum[3]);
        r_mat.m11 <= to_field(r_sum[4]);
        r_mat.m12 <= to_field(r_sum[5]);
        r_mat.m20 <= to_field(r_sum[6]);
        r_mat.m21 <= to_field(r_sum[7]);
        r_mat.m22 <= to_field(r_sum[8]);
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

// ===== hdl/euler_to_rotation_matrix_core.sv =====
// o_strobe follows an accepted item through each sine/cosine lane (angle reduction, squaring,
// the eight-step Horner chain, the sine multiply, the quadrant fold), then the matrix merge.
// Throughput: one item per cycle; every stage advances each clock and nothing stalls.
// busy is high only while i_rst_n is low; results cannot be held off by the receiver.
// Synchronous active-low reset clears the valid pipeline; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_rotation_matrix_core #(
    parameter int ANGLE_BITS = ertm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ertm_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire         [ertm_pkg::ANGLE_W-1:0] i_pitch_angle,
    input  wire         [ertm_pkg::ANGLE_W-1:0] i_yaw_angle,
    input  wire         [ertm_pkg::ANGLE_W-1:0] i_roll_angle,
    output logic                                o_strobe,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m00,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m01,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m02,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m10,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m11,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m12,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m20,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m21,
    output logic signed [ertm_pkg::FIELD_W-1:0] o_m22
);
    import ertm_pkg::*;

    localparam logic signed [FIELD_W-1:0] OUT_LIM = FIELD_W'(64'd1 << FRAC_BITS);

    logic                 accept;
    logic [TOTAL_LAT-1:0] r_vld;
    t_sincos              sc_pitch;
    t_sincos              sc_yaw;
    t_sincos              sc_roll;
    t_matrix              mat;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // valid travels alongside the free-running datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], accept};
        end
    end

    ertm_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_pitch (
        .i_clk   (i_clk),
        .i_angle (i_pitch_angle),
        .o_sc    (sc_pitch)
    );

    ertm_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_yaw (
        .i_clk   (i_clk),
        .i_angle (i_yaw_angle),
        .o_sc    (sc_yaw)
    );

    ertm_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_roll (
        .i_clk   (i_clk),
        .i_angle (i_roll_angle),
        .o_sc    (sc_roll)
    );

    ertm_matrix_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_pitch (sc_pitch),
        .i_yaw   (sc_yaw),
        .i_roll  (sc_roll),
        .o_mat   (mat)
    );

    assign o_strobe = r_vld[TOTAL_LAT-1];
    assign o_m00    = mat.m00;
    assign o_m01    = mat.m01;
    assign o_m02    = mat.m02;
    assign o_m10    = mat.m10;
    assign o_m11    = mat.m11;
    assign o_m12    = mat.m12;
    assign o_m20    = mat.m20;
    assign o_m21    = mat.m21;
    assign o_m22    = mat.m22;

    a_strobe_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, TOTAL_LAT))
        else $error("strobe without an item accepted one latency earlier");

    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    a_diag_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && FRAC_BITS <= 14) |->
            (o_m00 <= OUT_LIM && o_m00 >= -OUT_LIM &&
             o_m11 <= OUT_LIM && o_m11 >= -OUT_LIM &&
             o_m22 <= OUT_LIM && o_m22 >= -OUT_LIM))
        else $error("matrix entry beyond plus or minus one");

endmodule

`default_nettype wire
